// ===== rtl/pcf_pkg.sv =====
// Package for the pixel color filter: filter mode codes, register indexes,
// Q0.16 coefficient tables and shared widths. Depends on nothing.
package pcf_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned KW       = 9;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned ProdW    = CoefW + ChanW;
  localparam int unsigned DotW     = ProdW + 1;
  localparam int unsigned MixW     = 17;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [KW-1:0] OneQ8 = 9'd256;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [CoefW-1:0] coef_t;
  typedef logic [ProdW-1:0] prod_t;

  typedef enum logic [2:0] {
    ModePass   = 3'd0,
    ModeGray   = 3'd1,
    ModeSepia  = 3'd2,
    ModeInvert = 3'd3,
    ModeBright = 3'd4
  } mode_e;

  localparam logic [CfgIdxW-1:0] RegFilterMode     = 8'd0;
  localparam logic [CfgIdxW-1:0] RegBlendIntensity = 8'd1;

  localparam coef_t LumaCoef [3] = '{16'd19595, 16'd38470, 16'd7471};

  localparam coef_t SepiaCoef [3][3] = '{
    '{16'd25756, 16'd50397, 16'd12386},
    '{16'd22872, 16'd44958, 16'd11010},
    '{16'd17826, 16'd34996, 16'd8585}
  };

endpackage

// ===== rtl/pixel_color_filter.sv =====
// Top level of the pixel color filter: config registers and a five-stage pipeline.
// Depends on pcf_pkg and pcf_mix.
//
// Channel | Direction | Handshake               | Payload
// pixel in| input     | valid_i / stall_o       | red_in_i, green_in_i, blue_in_i
// pixel out| output   | valid_o / stall_i       | red_out_o, green_out_o, blue_out_o
// config  | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Accepted pixels pass stages 1 to 5; stage 5 raises valid_o. One pixel enters
// per cycle while stall_o is low. The coefficient multipliers, the three-term sums
// and the blend multipliers each own one stage. Reset clears the valid bits and
// sets filter_mode to pass and blend_intensity to 256. Each stage holds while the
// stage after it is full and stalled, so bubbles fill up and nothing is lost.
module pixel_color_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  pcf_pkg::chan_t                  red_in_i,
  input  pcf_pkg::chan_t                  green_in_i,
  input  pcf_pkg::chan_t                  blue_in_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output pcf_pkg::chan_t                  red_out_o,
  output pcf_pkg::chan_t                  green_out_o,
  output pcf_pkg::chan_t                  blue_out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [pcf_pkg::CfgDataW-1:0]    cfg_data_i
);

  logic [2:0]             mode_q;
  logic [pcf_pkg::KW-1:0] intensity_q;
  logic [pcf_pkg::KW-1:0] k_sat;
  logic                   bright;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pcf_pkg::ModePass;
      intensity_q <= pcf_pkg::OneQ8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pcf_pkg::RegFilterMode:     mode_q      <= cfg_data_i[2:0];
        pcf_pkg::RegBlendIntensity: intensity_q <= cfg_data_i[pcf_pkg::KW-1:0];
        default: ;
      endcase
    end
  end

  assign k_sat  = (intensity_q > pcf_pkg::OneQ8) ? pcf_pkg::OneQ8 : intensity_q;
  assign bright = (mode_q == pcf_pkg::ModeBright);

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4, en5;

  assign en5     = !valid_o || !stall_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  // Stage 1: input pixel.
  pcf_pkg::chan_t px1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      px1_q[0] <= red_in_i;
      px1_q[1] <= green_in_i;
      px1_q[2] <= blue_in_i;
    end
  end

  // Stage 2: coefficient products.
  pcf_pkg::chan_t px2_q [3];
  pcf_pkg::prod_t luma_d [3];
  pcf_pkg::prod_t luma_q [3];
  pcf_pkg::prod_t sepia_d [3][3];
  pcf_pkg::prod_t sepia_q [3][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      luma_d[j] = pcf_pkg::LumaCoef[j] * pcf_pkg::ProdW'(px1_q[j]);
      for (int r = 0; r < 3; r++) begin
        sepia_d[r][j] = pcf_pkg::SepiaCoef[r][j] * pcf_pkg::ProdW'(px1_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      px2_q   <= px1_q;
      luma_q  <= luma_d;
      sepia_q <= sepia_d;
    end
  end

  // Stage 3: sums, saturation and the filtered channel per mode.
  logic [pcf_pkg::DotW-1:0] luma_sum;
  logic [pcf_pkg::DotW-1:0] sepia_sum [3];
  pcf_pkg::chan_t           filt_d [3];
  pcf_pkg::chan_t           sepia_f [3];
  pcf_pkg::chan_t           px3_q [3];
  pcf_pkg::chan_t           filt_q [3];

  always_comb begin
    luma_sum = pcf_pkg::DotW'(luma_q[0]) + pcf_pkg::DotW'(luma_q[1])
             + pcf_pkg::DotW'(luma_q[2]);
    for (int r = 0; r < 3; r++) begin
      sepia_sum[r] = pcf_pkg::DotW'(sepia_q[r][0]) + pcf_pkg::DotW'(sepia_q[r][1])
                   + pcf_pkg::DotW'(sepia_q[r][2]);
      sepia_f[r] = sepia_sum[r][pcf_pkg::DotW-1] ? 8'hff : sepia_sum[r][23:16];
    end
    // Pass-through and brightness use the pixel itself as the filtered channel.
    for (int c = 0; c < 3; c++) begin
      case (mode_q)
        pcf_pkg::ModeGray:   filt_d[c] = luma_sum[23:16];
        pcf_pkg::ModeSepia:  filt_d[c] = sepia_f[c];
        pcf_pkg::ModeInvert: filt_d[c] = ~px2_q[c];
        default:             filt_d[c] = px2_q[c];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      px3_q  <= px2_q;
      filt_q <= filt_d;
    end
  end

  // Stage 4: blend or brightness products.
  logic [pcf_pkg::MixW-1:0] mix_d [3];
  logic [pcf_pkg::MixW-1:0] mix_q [3];

  for (genvar c = 0; c < 3; c++) begin : g_mix
    pcf_mix u_mix (
      .x_i      (px3_q[c]),
      .f_i      (filt_q[c]),
      .k_i      (k_sat),
      .bright_i (bright),
      .sum_o    (mix_d[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      mix_q <= mix_d;
    end
  end

  // Stage 5: shift down by eight and saturate into the output register.
  pcf_pkg::chan_t out_d [3];
  pcf_pkg::chan_t out_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      out_d[c] = mix_q[c][pcf_pkg::MixW-1] ? 8'hff : mix_q[c][15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en5) begin
      valid_o <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      out_q <= out_d;
    end
  end

  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> v1_q)
    else $error("accepted pixel did not reach stage 1");

  a_s4_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en5) |=> valid_o)
    else $error("stage 4 pixel lost on its way to the output");

  a_stall_holds_s4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !en4) |=> (v4_q && $stable(mix_q[0])))
    else $error("stage 4 changed while its successor was stalled");

  a_blend_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !bright) |-> (mix_q[0] <= 17'd65280 && mix_q[1] <= 17'd65280
                           && mix_q[2] <= 17'd65280))
    else $error("blend sum exceeds full scale");

  a_k_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_sat <= pcf_pkg::OneQ8)
    else $error("effective intensity above one");

endmodule

// ===== rtl/pcf_mix.sv =====
// Per-channel blend product: x*(256-k) + f*k, or x*(256+k) for brightness.
// Depends on pcf_pkg for widths.
module pcf_mix (
  input  pcf_pkg::chan_t              x_i,
  input  pcf_pkg::chan_t              f_i,
  input  logic [pcf_pkg::KW-1:0]      k_i,
  input  logic                        bright_i,
  output logic [pcf_pkg::MixW-1:0]    sum_o
);

  logic [pcf_pkg::KW:0]   x_weight;
  logic [pcf_pkg::KW-1:0] f_weight;

  always_comb begin
    if (bright_i) begin
      x_weight = {1'b0, pcf_pkg::OneQ8} + {1'b0, k_i};
      f_weight = '0;
    end else begin
      x_weight = {1'b0, pcf_pkg::OneQ8 - k_i};
      f_weight = k_i;
    end
    sum_o = pcf_pkg::MixW'(x_i) * pcf_pkg::MixW'(x_weight)
          + pcf_pkg::MixW'(f_i) * pcf_pkg::MixW'(f_weight);
  end

endmodule
